// File: design/itar_pkg.sv
// Shared types, constants and a helper function for the integer-to-ASCII converter.
package itar_pkg;

  // Radix register width and its limits.
  localparam int unsigned RADIX_W = 6;
  localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_NINE    = 6'd9;
  localparam logic [RADIX_W-1:0] DIGIT_TEN     = 6'd10;

  // Character codes.
  localparam int unsigned CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Status of the digit stack.
  typedef struct packed {
    logic empty;
    logic full;
  } stk_status_t;

  // Maps a digit value onto its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d > DIGIT_NINE) begin
      return d_ext - {1'b0, DIGIT_TEN} + CHAR_A;
    end
    return d_ext + CHAR_ZERO;
  endfunction

endpackage

// File: design/integer_to_ascii_radix.sv
// Top level: converts an integer, signed in base ten, into ASCII digits in a base from 2 to 36.
//
//  Channel  Direction  Payload
//  in_*     slave      tdata: value[VALUE_WIDTH-1:0], zero padded to whole bytes
//  out_*    master     tdata: character[6:0], zero bit; tlast: last
//  cfg_*    write      wdata: radix[5:0]
//
// A number is divided digit by digit in the serial divider (a load and one quotient bit
// per cycle for each digit); then the sign, if any, is sent, and each digit is read from
// the stack and loaded into the output register.
// rst_n is synchronous and active low; it sets the radix to ten and empties the block.
// A stalled output holds the character in the output register; the stack waits behind it.
module integer_to_ascii_radix import itar_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // in_tdata: value (bits VALUE_WIDTH-1:0)
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // out_tdata: character (bits 6:0)
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [7:0]                              out_tdata,
  output logic                                    out_tlast,
  input  logic                                    cfg_we,
  input  logic [RADIX_W-1:0]                      cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } state_t;

  state_t                 state_r;
  logic [RADIX_W-1:0]     radix_r;
  logic [RADIX_W-1:0]     base_r;
  logic                   neg_r;
  logic                   out_tvalid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_tlast_r;

  logic [VALUE_WIDTH-1:0] value;
  logic [RADIX_W-1:0]     base_eff;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   in_accept;
  logic                   out_free;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [RADIX_W-1:0]     div_divisor;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [RADIX_W-1:0]     div_rem;
  div_status_t            div_st;

  logic                   stk_push;
  logic                   stk_pop;
  logic [RADIX_W-1:0]     stk_rd_data;
  stk_status_t            stk_st;

  assign value     = in_tdata[VALUE_WIDTH-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Saturate the radix into the supported range.
  always_comb begin
    priority if (radix_r < RADIX_MIN) begin
      base_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base_eff = RADIX_MAX;
    end else begin
      base_eff = radix_r;
    end
  end

  // Sign only in decimal; the magnitude is formed as an unsigned pattern.
  assign neg_in = (base_eff == RADIX_DECIMAL) && value[VALUE_WIDTH-1];
  assign mag    = neg_in ? (~value + 1'b1) : value;

  // Divider and stack control.
  assign div_start    = in_accept ||
                        ((state_r == ST_DIV) && div_st.done && (div_quotient != '0));
  assign div_dividend = in_tready ? mag : div_quotient;
  assign div_divisor  = in_tready ? base_eff : base_r;
  assign stk_push     = (state_r == ST_DIV) && div_st.done;
  assign stk_pop      = (state_r == ST_READ);

  itar_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quotient),
    .remainder (div_rem),
    .status    (div_st)
  );

  itar_digit_stack #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stk_push),
    .push_data (div_rem),
    .pop       (stk_pop),
    .rd_data   (stk_rd_data),
    .status    (stk_st)
  );

  // Radix register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      neg_r        <= 1'b0;
      base_r       <= RADIX_RESET;
      out_char_r   <= '0;
      out_tlast_r  <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            neg_r   <= neg_in;
            base_r  <= base_eff;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_st.done && (div_quotient == '0)) begin
            state_r <= neg_r ? ST_SIGN : ST_READ;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_char_r   <= CHAR_MINUS;
            out_tlast_r  <= 1'b0;
            state_r      <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_char_r   <= digit_char(stk_rd_data);
            out_tlast_r  <= stk_st.empty;
            state_r      <= stk_st.empty ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_tlast_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("input taken again straight after an item was accepted");

  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_divider_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_st.busy)
    else $error("divider busy while the block waits for an item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed before it was taken");
`endif

endmodule

// File: design/itar_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, divisor up to 63.
module itar_divider import itar_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [RADIX_W-1:0]     remainder,
  output div_status_t            status
);

  localparam int unsigned CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [RADIX_W-1:0]     dvs_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [RADIX_W:0]       trial;
  logic                   q_bit;

  // One restoring step: bring down the next dividend bit and try a subtraction.
  always_comb begin
    trial   = {rem_r, quo_r[VALUE_WIDTH-1]};
    q_bit   = (trial >= {1'b0, dvs_r});
    rem_nxt = q_bit ? RADIX_W'(trial - {1'b0, dvs_r}) : RADIX_W'(trial);
    quo_nxt = {quo_r[VALUE_WIDTH-2:0], q_bit};
  end

  // Control: count the steps and flag completion for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_LAST;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient    = quo_r;
  assign remainder   = rem_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// File: design/itar_digit_stack.sv
// Last-in first-out digit store that reverses the digit order for output.
module itar_digit_stack import itar_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [RADIX_W-1:0] push_data,
  input  logic               pop,
  output logic [RADIX_W-1:0] rd_data,
  output stk_status_t        status
);

  localparam int unsigned DEPTH  = VALUE_WIDTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  logic [RADIX_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   top_idx;
  logic [RADIX_W-1:0] rd_data_r;

  assign top_idx = cnt_r - 1'b1;

  // Fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Storage: write at the fill count, registered read of the top entry.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[cnt_r[ADDR_W-1:0]] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[top_idx[ADDR_W-1:0]];
    end
  end

  assign rd_data      = rd_data_r;
  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == CNT_W'(DEPTH));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("digit pushed onto a full stack");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty && !push)
    else $error("digit popped from an empty stack or during a push");
`endif

endmodule
